FILE: src/spfp_pkg.sv
// Shared constants, types and helpers for the servo position frame parser.
// No dependencies.
`default_nettype none

package spfp_pkg;

  localparam int FRAME_BYTES = 64;
  localparam int SERVO_SLOTS = 32;

  localparam int BYTE_W = 8;
  localparam int ADDR_W = $clog2(FRAME_BYTES);
  localparam int IDX_W  = $clog2(FRAME_BYTES + 1);
  localparam int REC_W  = $clog2((FRAME_BYTES - 3) / 4 + 1);
  localparam int SLOT_W = $clog2(SERVO_SLOTS);
  localparam int POS_W  = 12;
  localparam int CFG_W  = 2;

  // First record starts after header and command bytes
  localparam int REC_BASE  = 2;
  localparam int REC_BYTES = 4;

  localparam logic [BYTE_W-1:0] HEADER_RST     = 8'hFF;
  localparam logic [BYTE_W-1:0] TERMINATOR_RST = 8'hFE;
  localparam logic [BYTE_W-1:0] REPLY_SHORT_RST = 8'hCC;
  localparam logic [BYTE_W-1:0] REPLY_FULL_RST  = 8'h99;

  typedef enum logic [CFG_W-1:0] {
    REG_HEADER      = 2'd0,
    REG_TERMINATOR  = 2'd1,
    REG_REPLY_SHORT = 2'd2,
    REG_REPLY_FULL  = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMD_RD,
    ST_CMD_CHK,
    ST_REC_RD,
    ST_REC_DONE
  } parse_state_t;

  // Store address modulo FRAME_BYTES; input is always below 2*FRAME_BYTES
  function automatic logic [ADDR_W-1:0] addr_wrap(input logic [ADDR_W:0] v);
    logic [ADDR_W:0] w;
    w = (v >= (ADDR_W+1)'(FRAME_BYTES)) ? v - (ADDR_W+1)'(FRAME_BYTES) : v;
    return w[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: src/spfp_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module spfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/servo_position_frame_parser.sv
// Servo position frame parser: byte capture, frame store and record walk.
// Depends on spfp_pkg and spfp_ram.
//
// Bytes are taken in while the parser is idle. When a terminator closes a
// frame the input stalls while the frame is parsed out of the byte store,
// which has a single registered read port: the command byte is fetched and
// checked, then each 4-byte record takes four reads, capture and emit, and
// the walk also waits while the output side stalls. A 64-byte store gives at
// most 15 records. A record result is held in an output register, so the last
// one may still wait there while new bytes are taken in.
`default_nettype none

module servo_position_frame_parser (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [spfp_pkg::CFG_W-1:0] cfg_index,
  input  wire logic [spfp_pkg::BYTE_W-1:0] cfg_data,
  input  wire logic                       in_valid,
  output      logic                       in_stall,
  input  wire logic [spfp_pkg::BYTE_W-1:0] rx_byte,
  output      logic                       out_valid,
  input  wire logic                       out_stall,
  output      logic [spfp_pkg::SLOT_W-1:0] servo_slot,
  output      logic [spfp_pkg::POS_W-1:0] position,
  output      logic                       checksum_ok,
  output      logic                       last
);

  import spfp_pkg::*;

  logic [BYTE_W-1:0] header_byte, terminator_byte, reply_code_short, reply_code_full;

  parse_state_t state, state_next;
  logic [IDX_W-1:0]  widx, widx_next;
  logic              capturing, capturing_next;
  logic [REC_W-1:0]  rec_total, rec_total_next;
  logic [REC_W-1:0]  rec, rec_next;
  logic [ADDR_W-1:0] ptr, ptr_next;
  logic [2:0]        k, k_next;
  logic [BYTE_W-1:0] rec_bytes [REC_BYTES];
  logic [BYTE_W-1:0] rec_bytes_next [REC_BYTES];

  logic              out_valid_next;
  logic [SLOT_W-1:0] servo_slot_next;
  logic [POS_W-1:0]  position_next;
  logic              checksum_ok_next, last_next;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  logic [1:0]        lane;
  logic [IDX_W-1:0]  widx_term;
  logic [BYTE_W-1:0] id_b, hi_b, lo_b, ck_b, xsum;
  logic              rec_ok;

  spfp_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(FRAME_BYTES)
  ) u_frame_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte      <= HEADER_RST;
      terminator_byte  <= TERMINATOR_RST;
      reply_code_short <= REPLY_SHORT_RST;
      reply_code_full  <= REPLY_FULL_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HEADER:      header_byte      <= cfg_data;
        REG_TERMINATOR:  terminator_byte  <= cfg_data;
        REG_REPLY_SHORT: reply_code_short <= cfg_data;
        REG_REPLY_FULL:  reply_code_full  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Record fields, from the captured id/high/low/check bytes
  assign lane   = k[1:0] - 2'd1;
  assign id_b   = rec_bytes[0];
  assign hi_b   = rec_bytes[1];
  assign lo_b   = rec_bytes[2];
  assign ck_b   = rec_bytes[3];
  assign xsum   = id_b ^ hi_b ^ lo_b;
  assign rec_ok = ck_b == {1'b0, xsum[6:0]};

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next       = state;
    widx_next        = widx;
    capturing_next   = capturing;
    rec_total_next   = rec_total;
    rec_next         = rec;
    ptr_next         = ptr;
    k_next           = k;
    rec_bytes_next   = rec_bytes;
    out_valid_next   = out_valid;
    servo_slot_next  = servo_slot;
    position_next    = position;
    checksum_ok_next = checksum_ok;
    last_next        = last;
    ram_we           = 1'b0;
    ram_waddr        = widx[ADDR_W-1:0];
    ram_wdata        = rx_byte;
    ram_raddr        = '0;
    widx_term        = widx;

    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (rx_byte == header_byte) begin
            ram_we         = 1'b1;
            ram_waddr      = '0;
            widx_next      = IDX_W'(1);
            capturing_next = 1'b1;
          end else if (rx_byte == terminator_byte && capturing) begin
            capturing_next = 1'b0;
            if (widx < IDX_W'(FRAME_BYTES)) begin
              ram_we    = 1'b1;
              widx_term = widx + IDX_W'(1);
            end
            // full store: terminator dropped, frame parsed at full length
            widx_next      = widx_term;
            rec_total_next = (widx_term >= IDX_W'(3)) ?
                             REC_W'((widx_term - IDX_W'(3)) >> 2) : '0;
            state_next     = ST_CMD_RD;
          end else if (capturing && widx < IDX_W'(FRAME_BYTES)) begin
            ram_we    = 1'b1;
            widx_next = widx + IDX_W'(1);
          end else if (widx >= IDX_W'(FRAME_BYTES)) begin
            widx_next = '0;
          end
        end
      end

      ST_CMD_RD: begin
        ram_raddr  = ADDR_W'(1);
        state_next = ST_CMD_CHK;
      end

      ST_CMD_CHK: begin
        if ((ram_rdata == reply_code_short || ram_rdata == reply_code_full) &&
            rec_total != '0) begin
          ptr_next   = ADDR_W'(REC_BASE);
          k_next     = '0;
          rec_next   = '0;
          state_next = ST_REC_RD;
        end else begin
          state_next = ST_IDLE;
        end
      end

      ST_REC_RD: begin
        // read issued at k, data captured at k+1
        if (k != 3'd4) begin
          ram_raddr = addr_wrap({1'b0, ptr} + (ADDR_W+1)'(k[1:0]));
        end
        if (k != 3'd0) begin
          rec_bytes_next[lane] = ram_rdata;
        end
        if (k == 3'd4) begin
          state_next = ST_REC_DONE;
        end else begin
          k_next = k + 3'd1;
        end
      end

      ST_REC_DONE: begin
        if (!out_valid || !out_stall) begin
          out_valid_next   = 1'b1;
          servo_slot_next  = id_b[SLOT_W-1:0];
          position_next    = rec_ok ? {hi_b[4:0], lo_b[6:0]} : '0;
          checksum_ok_next = rec_ok;
          last_next        = (rec == rec_total - REC_W'(1));
          if (rec == rec_total - REC_W'(1)) begin
            state_next = ST_IDLE;
          end else begin
            rec_next   = rec + REC_W'(1);
            ptr_next   = addr_wrap({1'b0, ptr} + (ADDR_W+1)'(REC_BYTES));
            k_next     = '0;
            state_next = ST_REC_RD;
          end
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      widx      <= '0;
      capturing <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      widx      <= widx_next;
      capturing <= capturing_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rec_total   <= rec_total_next;
    rec         <= rec_next;
    ptr         <= ptr_next;
    k           <= k_next;
    rec_bytes   <= rec_bytes_next;
    servo_slot  <= servo_slot_next;
    position    <= position_next;
    checksum_ok <= checksum_ok_next;
    last        <= last_next;
  end

endmodule

`default_nettype wire

FILE: src/spfp_checker.sv
// Port-level checks for the servo position frame parser, bound to the top.
// Depends on spfp_pkg.
`default_nettype none

module spfp_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [spfp_pkg::SLOT_W-1:0] servo_slot,
  input wire logic [spfp_pkg::POS_W-1:0]  position,
  input wire logic                        checksum_ok,
  input wire logic                        last
);

  import spfp_pkg::*;

  // a result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=>
      $stable(servo_slot) && $stable(position) && $stable(checksum_ok) && $stable(last))
    else $error("stalled result changed");

  // results come only from a frame walk, which holds the input side
  a_out_from_parse: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared outside a frame walk");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("reset left a result or a stall");

  // a failed check never reports a position
  a_bad_pos_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !checksum_ok |-> position == '0)
    else $error("nonzero position on checksum error");

endmodule

bind servo_position_frame_parser spfp_checker u_spfp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .servo_slot (servo_slot),
  .position   (position),
  .checksum_ok(checksum_ok),
  .last       (last)
);

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for servo_position_frame_parser: byte stream in, record results out.
// Depends on spfp_pkg and the parser RTL. It carries its own frame model for the expected results.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spfp_pkg::*;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  pos;
    logic              ok;
    logic              last;
  } rec_t;

  // One byte request; typed rows carry a hand-written record for their terminator
  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              typed;
    rec_t              rec;
  } rx_req_t;

  localparam rec_t NO_REC       = '0;
  localparam int   N_DIRECTED   = 26;
  localparam int   N_PHASES     = 6;
  localparam int   PHASE_ITEMS  = 20;
  localparam int   PARSE_CYCLES = 120;
  localparam int   SETTLE_MAX   = 20000;
  localparam int   LONG_HOLD    = 400;

  localparam cfg_reg_t REG_ORDER [4] = '{REG_HEADER, REG_TERMINATOR, REG_REPLY_SHORT,
                                         REG_REPLY_FULL};

  localparam rx_req_t DIRECTED [N_DIRECTED] = '{
    // bytes outside a frame are ignored
    {8'hFE, 1'b0, NO_REC},
    {8'h5A, 1'b0, NO_REC},
    // short reply, one good record at the top of every field
    {8'hFF, 1'b0, NO_REC},
    {8'hCC, 1'b0, NO_REC},
    {8'h1F, 1'b0, NO_REC},
    {8'h1F, 1'b0, NO_REC},
    {8'h7F, 1'b0, NO_REC},
    {8'h7F, 1'b0, NO_REC},
    {8'hFE, 1'b1, 5'd31, 12'hFFF, 1'b1, 1'b1},
    // full reply, all-zero record with a bad check
    {8'hFF, 1'b0, NO_REC},
    {8'h99, 1'b0, NO_REC},
    {8'h00, 1'b0, NO_REC},
    {8'h00, 1'b0, NO_REC},
    {8'h00, 1'b0, NO_REC},
    {8'h01, 1'b0, NO_REC},
    {8'hFE, 1'b1, 5'd0, 12'd0, 1'b0, 1'b1},
    // unknown command: nothing comes out
    {8'hFF, 1'b0, NO_REC},
    {8'h55, 1'b0, NO_REC},
    {8'h03, 1'b0, NO_REC},
    {8'h00, 1'b0, NO_REC},
    {8'h00, 1'b0, NO_REC},
    {8'h03, 1'b0, NO_REC},
    {8'hFE, 1'b0, NO_REC},
    // reply with no records
    {8'hFF, 1'b0, NO_REC},
    {8'hCC, 1'b0, NO_REC},
    {8'hFE, 1'b0, NO_REC}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  cfg_reg_t          cfg_index = REG_HEADER;
  logic [BYTE_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] rx_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [SLOT_W-1:0] servo_slot;
  logic [POS_W-1:0]  position;
  logic              checksum_ok;
  logic              last;

  servo_position_frame_parser dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .servo_slot  (servo_slot),
    .position    (position),
    .checksum_ok (checksum_ok),
    .last        (last)
  );

  // Shadow of the parser state and registers
  logic [BYTE_W-1:0] shadow_store [FRAME_BYTES];
  logic [IDX_W-1:0]  wr_idx = '0;
  logic              capturing = 1'b0;
  logic [POS_W-1:0]  pos_table [SERVO_SLOTS];
  logic [SERVO_SLOTS-1:0] slot_avail = '0;
  logic [BYTE_W-1:0] cur_hdr   = HEADER_RST;
  logic [BYTE_W-1:0] cur_term  = TERMINATOR_RST;
  logic [BYTE_W-1:0] cur_short = REPLY_SHORT_RST;
  logic [BYTE_W-1:0] cur_full  = REPLY_FULL_RST;

  rec_t              records_due [$];
  logic [BYTE_W-1:0] frame_q [$];

  int fail_count = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_frames = 0;
  bit no_idle = 1'b0;
  bit hold_off_req = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $error("timeout: %0d records still due", records_due.size());
    $display("tb: done, errors");
    $finish;
  end

  task automatic walk_frame(input bit typed);
    logic [BYTE_W-1:0] id, hi, lo, ck;
    int n_rec, base;
    rec_t r;
    if (shadow_store[1] != cur_short && shadow_store[1] != cur_full) return;
    slot_avail = '0;
    n_rec = (wr_idx >= 3) ? (int'(wr_idx) - 3) / 4 : 0;
    for (int k = 0; k < n_rec; k++) begin
      base = k * REC_BYTES + REC_BASE;
      id = shadow_store[base % FRAME_BYTES];
      hi = shadow_store[(base + 1) % FRAME_BYTES];
      lo = shadow_store[(base + 2) % FRAME_BYTES];
      ck = shadow_store[(base + 3) % FRAME_BYTES];
      r.slot = id[SLOT_W-1:0];
      r.ok   = (ck == {1'b0, id[6:0] ^ hi[6:0] ^ lo[6:0]});
      r.pos  = r.ok ? {hi[4:0], lo[6:0]} : '0;
      r.last = (k == n_rec - 1);
      if (r.ok) begin
        pos_table[r.slot] = {hi[4:0], lo[6:0]};
        slot_avail[r.slot] = 1'b1;
      end
      if (!typed) records_due.push_back(r);
    end
  endtask

  task automatic take_byte(input rx_req_t q);
    if (q.b == cur_hdr) begin
      shadow_store[0] = q.b;
      wr_idx = 1;
      capturing = 1'b1;
    end else if (q.b == cur_term && capturing) begin
      capturing = 1'b0;
      if (wr_idx < FRAME_BYTES) begin
        shadow_store[wr_idx[ADDR_W-1:0]] = q.b;
        wr_idx++;
      end
      if (q.typed) records_due.push_back(q.rec);
      walk_frame(q.typed);
    end else if (capturing && wr_idx < FRAME_BYTES) begin
      shadow_store[wr_idx[ADDR_W-1:0]] = q.b;
      wr_idx++;
    end else if (wr_idx >= FRAME_BYTES) begin
      // overflow: byte dropped, capture (if any) resumes at 0
      wr_idx = 0;
    end
  endtask

  task automatic send_byte(input rx_req_t q);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= q.b;
    do @(posedge clk); while (in_stall !== 1'b0);
    take_byte(q);
    n_sent++;
  endtask

  task automatic program_regs(input logic [BYTE_W-1:0] h, t, s, f);
    logic [BYTE_W-1:0] vals [4];
    vals = '{h, t, s, f};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_ORDER[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      case (REG_ORDER[i])
        REG_HEADER:      cur_hdr   = vals[i];
        REG_TERMINATOR:  cur_term  = vals[i];
        REG_REPLY_SHORT: cur_short = vals[i];
        REG_REPLY_FULL:  cur_full  = vals[i];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  // Wait for every due record, then for a trailing parse with no output
  task automatic settle();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (records_due.size() != 0 && waited < SETTLE_MAX) begin
      @(posedge clk);
      waited++;
    end
    if (records_due.size() != 0) begin
      $error("%0d expected records never arrived", records_due.size());
      fail_count++;
      records_due.delete();
    end
    repeat (PARSE_CYCLES) @(posedge clk);
  endtask

  // Payload byte, mostly steering clear of the delimiters
  function automatic logic [BYTE_W-1:0] data_byte();
    logic [BYTE_W-1:0] v;
    v = 8'($urandom);
    if ($urandom_range(0, 15) != 0)
      while (v == cur_hdr || v == cur_term) v = 8'($urandom);
    return v;
  endfunction

  task automatic build_frame(output bit counts);
    int kind, n_rec, pad, cut;
    logic [BYTE_W-1:0] id, hi, lo, ck;
    frame_q.delete();
    kind = $urandom_range(0, 19);
    counts = 1'b1;
    if (kind >= 18) begin
      counts = 1'b0;
      repeat ($urandom_range(1, 8)) frame_q.push_back(8'($urandom));
      return;
    end
    n_rec = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 15) : $urandom_range(0, 4);
    pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    if (kind == 13 || kind == 14) begin
      // store exactly full when the terminator lands
      n_rec = 15;
      pad = 2;
    end else if (kind == 15) begin
      // runs past the store end and wraps to 0
      n_rec = 15;
      pad = $urandom_range(3, 11);
    end
    frame_q.push_back(cur_hdr);
    case ($urandom_range(0, 9)) inside
      [0:3]:   frame_q.push_back(cur_short);
      [4:7]:   frame_q.push_back(cur_full);
      default: frame_q.push_back(data_byte());
    endcase
    for (int k = 0; k < n_rec; k++) begin
      id = data_byte();
      hi = data_byte();
      lo = data_byte();
      ck = ($urandom_range(0, 5) == 0) ? data_byte() : {1'b0, id[6:0] ^ hi[6:0] ^ lo[6:0]};
      frame_q.push_back(id);
      frame_q.push_back(hi);
      frame_q.push_back(lo);
      frame_q.push_back(ck);
    end
    repeat (pad) frame_q.push_back(data_byte());
    if (kind >= 16) begin
      // broken frame: cut short, no terminator
      cut = $urandom_range(1, frame_q.size());
      while (frame_q.size() > cut) void'(frame_q.pop_back());
    end else begin
      frame_q.push_back(cur_term);
    end
  endtask

  task automatic cmp_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin : receiver
    int hold;
    bit hold_taken;
    rec_t e;
    hold_taken = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 15);
      if (hold_off_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
      if (records_due.size() == 0) begin
        $error("record with nothing due: slot %0d position %0d", servo_slot, position);
        fail_count++;
      end else begin
        e = records_due.pop_front();
        cmp_field("servo_slot", e.slot, servo_slot);
        cmp_field("position", e.pos, position);
        cmp_field("checksum_ok", e.ok, checksum_ok);
        cmp_field("last", e.last, last);
        n_checked++;
      end
    end
  end

  initial begin : stimulus
    int counted;
    bit counts;
    logic [BYTE_W-1:0] rh, rt;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    rh = 8'($urandom);
    do rt = 8'($urandom); while (rt == rh);
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: for (int i = 0; i < N_DIRECTED; i++) send_byte(DIRECTED[i]);
        1: program_regs(8'h00, 8'hFF, 8'h01, 8'hFE);
        2: begin
          hold_off_req = 1'b1;
          program_regs(8'h80, 8'h7F, 8'hFF, 8'h00);
        end
        3: program_regs(8'hFF, 8'h00, 8'h00, 8'h80);
        4: program_regs(rh, rt, 8'($urandom), 8'($urandom));
        default: program_regs(HEADER_RST, TERMINATOR_RST, REPLY_SHORT_RST, REPLY_FULL_RST);
      endcase
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        build_frame(counts);
        no_idle = ($urandom_range(0, 4) == 0);
        foreach (frame_q[j]) send_byte({frame_q[j], 1'b0, NO_REC});
        if (counts) counted += frame_q.size();
        n_frames++;
      end
      no_idle = 1'b0;
      settle();
    end
    $display("tb: %0d bytes over %0d register settings, %0d records checked", n_sent,
             N_PHASES, n_checked);
    $display("tb: %0d random frames incl. full-store, wrap, broken and noise", n_frames);
    if (fail_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/spfp_pkg.sv
src/spfp_ram.sv
src/servo_position_frame_parser.sv
src/spfp_checker.sv
verif/tb.sv
